@@ rtl/msp_pkg.sv @@
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants for the moving sphere / plane test
// Fixed point format, field widths, queue records and status codes.
// ----------------------------------------------------------------------------
package msp_pkg;

   localparam int FRAC_BITS = 16;
   localparam int PW        = 64;              // full 32x32 product
   localparam int SW        = PW - FRAC_BITS;  // product after the fraction drop
   localparam int DW        = SW + 3;          // signed distance
   localparam int EW        = SW + 2;          // signed denominator
   localparam int AW        = EW;              // denominator magnitude
   localparam int NW        = DW + FRAC_BITS;  // scaled numerator
   localparam int RW        = AW + 32;         // divider compare width
   localparam int CW        = SW + 2;          // contact point sum
   localparam int QDEPTH    = 8;
   localparam int QAW       = $clog2(QDEPTH);
   localparam int NST       = 32;              // divider stages, 31 quotient bits

   typedef enum logic [1:0] {
      ST_NONE    = 2'd0,
      ST_HIT     = 2'd1,
      ST_OVERLAP = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_NORMAL_X     = 2'd0,
      CSR_NORMAL_Y     = 2'd1,
      CSR_NORMAL_Z     = 2'd2,
      CSR_PLANE_OFFSET = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic signed [31:0] nz;
      logic signed [31:0] d;
   } plane_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic        [30:0] r;
   } sphere_type;

   typedef struct packed {
      status_type       status;
      logic             pos;     // distance strictly positive
      logic [NW-1:0]    num;
      logic [AW-1:0]    aden;
      sphere_type       sph;
   } qrec_type;

   typedef struct packed {
      logic             head_valid;
      logic [QAW:0]     count;
   } qstat_type;

   function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] hi;
      logic signed [CW-1:0] lo;
      hi = CW'(32'sh7FFFFFFF);
      lo = CW'($signed(32'h80000000));
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return $signed(32'h80000000);
      end
      return v[31:0];
   endfunction

endpackage

@@ rtl/moving_sphere_plane_test.sv @@
// ----------------------------------------------------------------------------
// moving_sphere_plane_test: moving sphere against a fixed plane
// Reports overlap, miss, or contact time and point for each sphere beat.
// ----------------------------------------------------------------------------
// Usage:
//   Load the plane (unit normal, offset; Q16.16) through the csr_ port while
//   idle. Reset leaves the normal at +Y and the offset at zero.
//   Send one sphere per beat on the req_ channel (valid/stall). One rsp_ beat
//   returns per sphere, in order: status, contact time, contact point.
//   An accepted beat reaches its result through 3 front stages, the queue,
//   32 divider stages, the point multiply stage and the output register.
//   Throughput is one beat per cycle unless a stall holds it. Each divider
//   stage past the first adds a quotient bit; each holds a different sphere.
//   When rsp_stall is high with a result valid, the whole back pipeline
//   holds; the front keeps running into the 8-entry queue and raises
//   req_stall once the queue plus the beats in the front stages would fill it.
//   Reset clears all valid bits and the queue; no results are pending after.
// ----------------------------------------------------------------------------
module moving_sphere_plane_test (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic        [30:0] req_radius,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_contact_time,
   output logic signed [31:0] rsp_contact_x,
   output logic signed [31:0] rsp_contact_y,
   output logic signed [31:0] rsp_contact_z,
   input  logic               csr_write_enable,
   input  logic        [1:0]  csr_index,
   input  logic        [31:0] csr_write_data
);
   import msp_pkg::*;

   plane_type   plane_ff;
   sphere_type  sph;
   logic        accept;
   logic        f_valid;
   qrec_type    f_rec;
   logic [1:0]  busy;
   qrec_type    head_rec;
   qstat_type   qstat;
   logic        pop;
   logic [QAW+1:0] credit_used;

   // plane registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff.nx <= '0;
         plane_ff.ny <= 32'sd1 <<< FRAC_BITS;
         plane_ff.nz <= '0;
         plane_ff.d  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NORMAL_X:     plane_ff.nx <= $signed(csr_write_data);
            CSR_NORMAL_Y:     plane_ff.ny <= $signed(csr_write_data);
            CSR_NORMAL_Z:     plane_ff.nz <= $signed(csr_write_data);
            CSR_PLANE_OFFSET: plane_ff.d  <= $signed(csr_write_data);
            default: ;
         endcase
      end
   end

   // hold off new beats once the queue could not absorb everything in flight
   assign credit_used = (QAW+2)'(qstat.count) + (QAW+2)'(busy);
   assign req_stall   = credit_used >= (QAW+2)'(QDEPTH);
   assign accept      = req_valid && !req_stall;

   assign sph.cx = req_center_x;
   assign sph.cy = req_center_y;
   assign sph.cz = req_center_z;
   assign sph.vx = req_vel_x;
   assign sph.vy = req_vel_y;
   assign sph.vz = req_vel_z;
   assign sph.r  = req_radius;

   msp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_sphere  (sph),
      .plane      (plane_ff),
      .out_valid  (f_valid),
      .out_rec    (f_rec),
      .busy_count (busy)
   );

   msp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_valid),
      .push_rec (f_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .stat     (qstat)
   );

   msp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .plane            (plane_ff),
      .head_valid       (qstat.head_valid),
      .head_rec         (head_rec),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_contact_time (rsp_contact_time),
      .rsp_contact_x    (rsp_contact_x),
      .rsp_contact_y    (rsp_contact_y),
      .rsp_contact_z    (rsp_contact_z)
   );

   // queue plus front stages never exceed the queue depth
   a_credit: assert property (@(posedge clock) disable iff (reset)
      credit_used <= (QAW+2)'(QDEPTH))
      else $error("queue credit overrun");

   // a miss carries all-zero result fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NONE) |->
         (rsp_contact_time == '0 && rsp_contact_x == '0 &&
          rsp_contact_y == '0 && rsp_contact_z == '0))
      else $error("miss with nonzero fields");

   // overlap reports time zero
   a_overlap_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OVERLAP) |-> rsp_contact_time == '0)
      else $error("overlap with nonzero time");

   // a hit time is never negative
   a_hit_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_HIT) |-> !rsp_contact_time[31])
      else $error("negative contact time");

   // a queue pop only happens with data present
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> qstat.count != '0)
      else $error("pop from empty queue");

endmodule

@@ rtl/msp_front.sv @@
// ----------------------------------------------------------------------------
// msp_front: distance, denominator and classification
// Three stages: products, dot sums, then overlap / miss / hit sorting.
// ----------------------------------------------------------------------------
module msp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  msp_pkg::sphere_type in_sphere,
   input  msp_pkg::plane_type  plane,
   output logic                out_valid,
   output msp_pkg::qrec_type   out_rec,
   output logic [1:0]          busy_count
);
   import msp_pkg::*;

   logic                 v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0] prod_ff [6];
   logic signed [PW-1:0] prod_in [6];
   sphere_type           sph1_ff, sph2_ff;
   logic signed [DW-1:0] dist_ff, dist_in;
   logic signed [EW-1:0] denom_ff, denom_in;
   qrec_type             rec3_ff, rec3_in;
   logic [DW-1:0]        adist;

   always_comb begin
      prod_in[0] = plane.nx * in_sphere.cx;
      prod_in[1] = plane.ny * in_sphere.cy;
      prod_in[2] = plane.nz * in_sphere.cz;
      prod_in[3] = plane.nx * in_sphere.vx;
      prod_in[4] = plane.ny * in_sphere.vy;
      prod_in[5] = plane.nz * in_sphere.vz;
   end

   // floor each term by the fraction width, then sum exactly
   always_comb begin
      dist_in  = DW'(prod_ff[0] >>> FRAC_BITS) + DW'(prod_ff[1] >>> FRAC_BITS)
               + DW'(prod_ff[2] >>> FRAC_BITS) - DW'(plane.d);
      denom_in = EW'(prod_ff[3] >>> FRAC_BITS) + EW'(prod_ff[4] >>> FRAC_BITS)
               + EW'(prod_ff[5] >>> FRAC_BITS);
   end

   always_comb begin
      adist        = dist_ff[DW-1] ? DW'(-dist_ff) : DW'(dist_ff);
      rec3_in.sph  = sph2_ff;
      rec3_in.pos  = !dist_ff[DW-1] && (dist_ff != '0);
      rec3_in.aden = denom_ff[EW-1] ? AW'(-denom_ff) : AW'(denom_ff);
      rec3_in.num  = NW'(adist - DW'(sph2_ff.r)) << FRAC_BITS;
      if (adist <= DW'(sph2_ff.r)) begin
         rec3_in.status = ST_OVERLAP;
      end else if (denom_ff == '0 || (!denom_ff[EW-1]) == rec3_in.pos) begin
         rec3_in.status = ST_NONE;
      end else begin
         rec3_in.status = ST_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      prod_ff  <= prod_in;
      sph1_ff  <= in_sphere;
      dist_ff  <= dist_in;
      denom_ff <= denom_in;
      sph2_ff  <= sph1_ff;
      rec3_ff  <= rec3_in;
   end

   assign out_valid  = v3_ff;
   assign out_rec    = rec3_ff;
   assign busy_count = 2'(v1_ff) + 2'(v2_ff) + 2'(v3_ff);

endmodule

@@ rtl/msp_queue.sv @@
// ----------------------------------------------------------------------------
// msp_queue: short record queue between front and back
// Register array with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module msp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  msp_pkg::qrec_type push_rec,
   input  logic              pop,
   output msp_pkg::qrec_type head_rec,
   output msp_pkg::qstat_type stat
);
   import msp_pkg::*;

   qrec_type         mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ff, rd_ff;
   logic [QAW:0]     count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (QAW+1)'(push) - (QAW+1)'(pop);
      end
      if (push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

   assign head_rec        = mem_ff[rd_ff];
   assign stat.head_valid = (count_ff != '0);
   assign stat.count      = count_ff;

endmodule

@@ rtl/msp_back.sv @@
// ----------------------------------------------------------------------------
// msp_back: contact time divider and contact point
// Pipelined restoring divider, one quotient bit a stage, then the point.
// ----------------------------------------------------------------------------
module msp_back (
   input  logic                clock,
   input  logic                reset,
   input  msp_pkg::plane_type  plane,
   input  logic                head_valid,
   input  msp_pkg::qrec_type   head_rec,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic signed [31:0]  rsp_contact_time,
   output logic signed [31:0]  rsp_contact_x,
   output logic signed [31:0]  rsp_contact_y,
   output logic signed [31:0]  rsp_contact_z
);
   import msp_pkg::*;

   logic                 en;
   logic                 dv_ff  [NST];
   qrec_type             rec_ff [NST];
   logic [NW-1:0]        rem_ff [NST];
   logic [NW-1:0]        rem_in [NST];
   logic [30:0]          q_ff   [NST];
   logic [30:0]          q_in   [NST];
   logic                 ovf_ff [NST];
   logic                 ovf0;
   logic [RW-1:0]        shifted;
   logic [30:0]          t31;

   logic                 mv_ff;
   qrec_type             mrec_ff;
   logic signed [31:0]   mt_ff;
   logic signed [PW-1:0] tv_ff [3];
   logic signed [PW-1:0] rn_ff [3];
   logic signed [31:0]   tin;
   logic signed [31:0]   rs;

   logic                 ov_ff;
   logic [1:0]           ost_ff;
   logic signed [31:0]   ot_ff, ox_ff, oy_ff, oz_ff;
   logic signed [CW-1:0] sum_x, sum_y, sum_z;

   assign en  = !ov_ff || !rsp_stall;
   assign pop = en && head_valid;

   // quotient at or above 2^31 saturates
   assign ovf0 = RW'(head_rec.num) >= (RW'(head_rec.aden) << 31);

   always_comb begin
      rem_in[0] = head_rec.num;
      q_in[0]   = '0;
      shifted   = '0;
      for (int k = 1; k < NST; k++) begin
         shifted   = RW'(rec_ff[k-1].aden) << (NST - 1 - k);
         rem_in[k] = rem_ff[k-1];
         q_in[k]   = q_ff[k-1];
         if (RW'(rem_ff[k-1]) >= shifted) begin
            rem_in[k] = NW'(RW'(rem_ff[k-1]) - shifted);
            q_in[k][NST-1-k] = 1'b1;
         end
      end
   end

   always_comb begin
      t31 = ovf_ff[NST-1] ? 31'h7FFFFFFF : q_ff[NST-1];
      tin = $signed({1'b0, t31});
      rs  = rec_ff[NST-1].pos ? $signed({1'b0, rec_ff[NST-1].sph.r})
                              : -$signed({1'b0, rec_ff[NST-1].sph.r});
   end

   always_comb begin
      sum_x = CW'(mrec_ff.sph.cx) + CW'(tv_ff[0] >>> FRAC_BITS)
            - CW'(rn_ff[0] >>> FRAC_BITS);
      sum_y = CW'(mrec_ff.sph.cy) + CW'(tv_ff[1] >>> FRAC_BITS)
            - CW'(rn_ff[1] >>> FRAC_BITS);
      sum_z = CW'(mrec_ff.sph.cz) + CW'(tv_ff[2] >>> FRAC_BITS)
            - CW'(rn_ff[2] >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            dv_ff[k] <= 1'b0;
         end
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= head_valid;
         for (int k = 1; k < NST; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         mv_ff <= dv_ff[NST-1];
         ov_ff <= mv_ff;
      end
      if (en) begin
         rec_ff[0] <= head_rec;
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         ovf_ff[0] <= ovf0;
         for (int k = 1; k < NST; k++) begin
            rec_ff[k] <= rec_ff[k-1];
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            ovf_ff[k] <= ovf_ff[k-1];
         end
         mrec_ff  <= rec_ff[NST-1];
         mt_ff    <= tin;
         tv_ff[0] <= tin * rec_ff[NST-1].sph.vx;
         tv_ff[1] <= tin * rec_ff[NST-1].sph.vy;
         tv_ff[2] <= tin * rec_ff[NST-1].sph.vz;
         rn_ff[0] <= rs * plane.nx;
         rn_ff[1] <= rs * plane.ny;
         rn_ff[2] <= rs * plane.nz;
         ost_ff   <= mrec_ff.status;
         case (mrec_ff.status)
            ST_HIT: begin
               ot_ff <= mt_ff;
               ox_ff <= sat32(sum_x);
               oy_ff <= sat32(sum_y);
               oz_ff <= sat32(sum_z);
            end
            ST_OVERLAP: begin
               ot_ff <= '0;
               ox_ff <= mrec_ff.sph.cx;
               oy_ff <= mrec_ff.sph.cy;
               oz_ff <= mrec_ff.sph.cz;
            end
            default: begin
               ot_ff <= '0;
               ox_ff <= '0;
               oy_ff <= '0;
               oz_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid        = ov_ff;
   assign rsp_status       = ost_ff;
   assign rsp_contact_time = ot_ff;
   assign rsp_contact_x    = ox_ff;
   assign rsp_contact_y    = oy_ff;
   assign rsp_contact_z    = oz_ff;

endmodule
